/* hw/rtl/bmfns_pkg.sv */
// Shared constants, operation codes and the lowest-set-bit encoder for the bitmap block.
package bmfns_pkg;

    localparam int MAX_BITS_DEF     = 4096;
    localparam int WORD_BITS        = 64;
    localparam int LOW_BITS         = 6;
    localparam int INDEX_W          = 12;
    localparam int VALID_BITS_W     = 13;
    localparam int VALID_BITS_RESET = 4096;

    typedef enum logic [1:0] {
        FUNC_SET   = 2'd0,
        FUNC_CLEAR = 2'd1,
        FUNC_TEST  = 2'd2,
        FUNC_FIND  = 2'd3
    } func_t;

    // Position of the lowest set bit of a nonzero word.
    function automatic logic [LOW_BITS-1:0] lowest_set(input logic [WORD_BITS-1:0] w);
        logic [LOW_BITS-1:0] n;
        n = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (w[i]) begin
                n = LOW_BITS'(i);
            end
        end
        return n;
    endfunction

endpackage

/* hw/rtl/bmfns_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
module bmfns_ram #(
    parameter int  WIDTH = 64,
    parameter int  DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/bitmap_set_with_next_set_search_top.sv */
// Bitmap of MAX_BITS bits held in a word RAM: set, clear, test and find-next-set requests.
//
// The bit set lives in one RAM of MAX_BITS/64 words of 64 bits with a registered
// read. After reset the block runs a clearing pass that writes every word to zero,
// one word per cycle; requests are stalled during it, while writes to valid_bits
// are taken at any time. One request is worked at a time. An index error goes
// straight to the finish state; set and clear read the word, then modify and write
// it back, and test reads the word and takes the bit. Find-next reads the start
// word and then one further word per cycle until it meets a nonzero word or runs
// off the end; a hit then passes through an encode state. A result waits in the
// finish state until the output register is free, and the next request is taken
// in the idle state after the result is loaded. A new request is taken while a
// finished result still waits in the output register.
module bitmap_set_with_next_set_search_top
    import bmfns_pkg::*;
#(
    parameter int MAX_BITS = MAX_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [VALID_BITS_W-1:0] cfg_wr_data,
    input  logic                    req_valid,
    output logic                    req_stall,
    input  logic [1:0]              func,
    input  logic [INDEX_W-1:0]      bit_index,
    output logic                    rsp_valid,
    input  logic                    rsp_stall,
    output logic                    bit_value,
    output logic                    found,
    output logic [INDEX_W-1:0]      next_index,
    output logic                    index_error
);

    localparam int NUM_WORDS = MAX_BITS / WORD_BITS;
    localparam int WORD_AW   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int POS_W     = WORD_AW + LOW_BITS;
    localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(NUM_WORDS - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_ENCODE,
        ST_FINISH
    } state_t;

    state_t                  state_reg,       state_next;
    logic [VALID_BITS_W-1:0] valid_bits_reg,  valid_bits_next;
    logic [WORD_AW-1:0]      addr_reg,        addr_next;
    func_t                   func_reg,        func_next;
    logic [LOW_BITS-1:0]     low_reg,         low_next;
    logic [WORD_BITS-1:0]    hit_word_reg,    hit_word_next;
    logic                    res_value_reg,   res_value_next;
    logic                    res_found_reg,   res_found_next;
    logic [INDEX_W-1:0]      res_index_reg,   res_index_next;
    logic                    res_err_reg,     res_err_next;
    logic                    rsp_valid_reg,   rsp_valid_next;
    logic                    bit_value_reg,   bit_value_next;
    logic                    found_reg,       found_next;
    logic [INDEX_W-1:0]      next_index_reg,  next_index_next;
    logic                    index_error_reg, index_error_next;

    logic                    ram_wr_en;
    logic [WORD_AW-1:0]      ram_wr_addr;
    logic [WORD_BITS-1:0]    ram_wr_data;
    logic                    ram_rd_en;
    logic [WORD_AW-1:0]      ram_rd_addr;
    logic [WORD_BITS-1:0]    ram_rd_data;

    logic                    req_xfer;
    logic                    rsp_xfer;
    logic                    rsp_free;
    logic                    req_err;
    logic [WORD_BITS-1:0]    bit_mask;
    logic [WORD_BITS-1:0]    above_word;
    logic [POS_W-1:0]        hit_pos;
    logic                    hit_in_range;

    bmfns_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_words (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign req_stall = (state_reg != ST_IDLE);
    assign req_xfer  = req_valid && !req_stall;
    assign rsp_xfer  = rsp_valid_reg && !rsp_stall;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;

    // An index is an error if it reaches either the programmed length or the store size.
    assign req_err = ({1'b0, bit_index} >= valid_bits_reg) || (32'(bit_index) >= MAX_BITS);

    assign bit_mask   = WORD_BITS'(1) << low_reg;
    // Bits strictly above the start bit; empty when the start is the top bit of the word.
    assign above_word = ram_rd_data & ((~(WORD_BITS'(0)) << low_reg) << 1);

    assign hit_pos      = {addr_reg, lowest_set(hit_word_reg)};
    assign hit_in_range = (32'(hit_pos) < 32'(valid_bits_reg));

    always_comb
    begin
        state_next       = state_reg;
        valid_bits_next  = valid_bits_reg;
        addr_next        = addr_reg;
        func_next        = func_reg;
        low_next         = low_reg;
        hit_word_next    = hit_word_reg;
        res_value_next   = res_value_reg;
        res_found_next   = res_found_reg;
        res_index_next   = res_index_reg;
        res_err_next     = res_err_reg;
        rsp_valid_next   = rsp_valid_reg;
        bit_value_next   = bit_value_reg;
        found_next       = found_reg;
        next_index_next  = next_index_reg;
        index_error_next = index_error_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = addr_reg;
        ram_wr_data = '0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = addr_reg + WORD_AW'(1);

        if (cfg_wr_en)
        begin
            valid_bits_next = cfg_wr_data;
        end

        if (rsp_xfer)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_wr_en = 1'b1;
                addr_next = addr_reg + WORD_AW'(1);
                if (addr_reg == LAST_WORD)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                ram_rd_addr = WORD_AW'(bit_index >> LOW_BITS);
                if (req_xfer)
                begin
                    func_next      = func_t'(func);
                    low_next       = bit_index[LOW_BITS-1:0];
                    addr_next      = WORD_AW'(bit_index >> LOW_BITS);
                    res_value_next = 1'b0;
                    res_found_next = 1'b0;
                    res_index_next = '0;
                    res_err_next   = req_err;
                    if (req_err)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        ram_rd_en  = 1'b1;
                        state_next = ST_EXEC;
                    end
                end
            end

            ST_EXEC:
            begin
                unique case (func_reg)
                    FUNC_SET:
                    begin
                        ram_wr_en   = 1'b1;
                        ram_wr_data = ram_rd_data | bit_mask;
                        state_next  = ST_FINISH;
                    end
                    FUNC_CLEAR:
                    begin
                        ram_wr_en   = 1'b1;
                        ram_wr_data = ram_rd_data & ~bit_mask;
                        state_next  = ST_FINISH;
                    end
                    FUNC_TEST:
                    begin
                        res_value_next = ram_rd_data[low_reg];
                        state_next     = ST_FINISH;
                    end
                    FUNC_FIND:
                    begin
                        if (above_word != '0)
                        begin
                            hit_word_next = above_word;
                            state_next    = ST_ENCODE;
                        end
                        else if (addr_reg == LAST_WORD)
                        begin
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            ram_rd_en  = 1'b1;
                            addr_next  = addr_reg + WORD_AW'(1);
                            state_next = ST_SCAN;
                        end
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end

            ST_SCAN:
            begin
                // The word at addr_reg is checked while the read of the next one goes out.
                if (ram_rd_data != '0)
                begin
                    hit_word_next = ram_rd_data;
                    state_next    = ST_ENCODE;
                end
                else if (addr_reg == LAST_WORD)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    ram_rd_en = 1'b1;
                    addr_next = addr_reg + WORD_AW'(1);
                end
            end

            ST_ENCODE:
            begin
                // A set bit past the programmed length counts as not found.
                res_found_next = hit_in_range;
                res_index_next = hit_in_range ? INDEX_W'(hit_pos) : '0;
                state_next     = ST_FINISH;
            end

            ST_FINISH:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next   = 1'b1;
                    bit_value_next   = res_value_reg;
                    found_next       = res_found_reg;
                    next_index_next  = res_index_reg;
                    index_error_next = res_err_reg;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            valid_bits_reg  <= VALID_BITS_W'(VALID_BITS_RESET);
            addr_reg        <= '0;
            func_reg        <= FUNC_SET;
            low_reg         <= '0;
            hit_word_reg    <= '0;
            res_value_reg   <= 1'b0;
            res_found_reg   <= 1'b0;
            res_index_reg   <= '0;
            res_err_reg     <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            bit_value_reg   <= 1'b0;
            found_reg       <= 1'b0;
            next_index_reg  <= '0;
            index_error_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            valid_bits_reg  <= valid_bits_next;
            addr_reg        <= addr_next;
            func_reg        <= func_next;
            low_reg         <= low_next;
            hit_word_reg    <= hit_word_next;
            res_value_reg   <= res_value_next;
            res_found_reg   <= res_found_next;
            res_index_reg   <= res_index_next;
            res_err_reg     <= res_err_next;
            rsp_valid_reg   <= rsp_valid_next;
            bit_value_reg   <= bit_value_next;
            found_reg       <= found_next;
            next_index_reg  <= next_index_next;
            index_error_reg <= index_error_next;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign bit_value   = bit_value_reg;
    assign found       = found_reg;
    assign next_index  = next_index_reg;
    assign index_error = index_error_reg;

    // The clearing pass writes zero to every word it visits.
    a_clear_writes_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (ram_wr_en && (ram_wr_data == '0)))
        else $error("clearing pass did not write a zero word");

    // A search never modifies the store.
    a_no_write_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN) || (state_reg == ST_ENCODE)) |-> !ram_wr_en)
        else $error("RAM write during a find-next scan");

    // A result has at most one of its flags raised.
    a_result_flags: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> ($countones({bit_value_reg, found_reg, index_error_reg}) <= 1))
        else $error("result carries conflicting flags");

    // A finished result moves into a free output register on the next edge.
    a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FINISH) && rsp_free) |=> (rsp_valid_reg && (state_reg == ST_IDLE)))
        else $error("finished result was not loaded");

endmodule

/* tb/bitmap_checker.sv */
// Checker for the bitmap block: tracks the bit set, predicts every response and compares it.
`timescale 1ns / 100ps

module bitmap_checker
    import bmfns_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [VALID_BITS_W-1:0] cfg_wr_data,
    input  logic                    req_valid,
    input  logic                    req_stall,
    input  logic [1:0]              func,
    input  logic [INDEX_W-1:0]      bit_index,
    input  logic                    rsp_valid,
    input  logic                    rsp_stall,
    input  logic                    bit_value,
    input  logic                    found,
    input  logic [INDEX_W-1:0]      next_index,
    input  logic                    index_error,
    output int                      fail_count,
    output int                      pending,
    output int                      hit_count,
    output int                      flagged_count
);

    localparam int MAP_BITS  = MAX_BITS_DEF;
    localparam int NUM_WORDS = MAP_BITS / WORD_BITS;

    typedef struct packed {
        logic               bit_value;
        logic               found;
        logic [INDEX_W-1:0] next_index;
        logic               index_error;
    } map_result_t;

    logic [WORD_BITS-1:0]    map_words [NUM_WORDS];
    logic [VALID_BITS_W-1:0] length_reg;
    map_result_t             pending_results [$];
    map_result_t             want;

    function automatic map_result_t apply_request(input func_t op,
                                                  input logic [INDEX_W-1:0] idx);
        map_result_t res;
        int unsigned lim;
        int unsigned wrd;
        int unsigned pos;
        res = '0;
        lim = (length_reg > MAP_BITS) ? MAP_BITS : length_reg;
        wrd = idx >> LOW_BITS;
        if (idx >= lim)
        begin
            res.index_error = 1'b1;
            return res;
        end
        case (op)
            FUNC_SET:   map_words[wrd][idx[LOW_BITS-1:0]] = 1'b1;
            FUNC_CLEAR: map_words[wrd][idx[LOW_BITS-1:0]] = 1'b0;
            FUNC_TEST:  res.bit_value = map_words[wrd][idx[LOW_BITS-1:0]];
            FUNC_FIND:
            begin
                // The search covers the whole store, so a first set bit that lies
                // beyond the current length ends it as not found.
                pos = idx + 1;
                while (pos < MAP_BITS && !map_words[pos / WORD_BITS][pos % WORD_BITS])
                    pos++;
                if (pos < lim)
                begin
                    res.found      = 1'b1;
                    res.next_index = pos[INDEX_W-1:0];
                end
            end
        endcase
        return res;
    endfunction

    task automatic check_field(input string name, input logic [INDEX_W-1:0] exp_val,
                               input logic [INDEX_W-1:0] act_val);
        if (act_val !== exp_val)
        begin
            fail_count++;
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (map_words[i])
                map_words[i] = '0;
            length_reg = VALID_BITS_W'(VALID_BITS_RESET);
            pending_results.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                length_reg = cfg_wr_data;
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    fail_count++;
                    $error("response transfer with no request outstanding");
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("bit_value", INDEX_W'(want.bit_value), INDEX_W'(bit_value));
                    check_field("found", INDEX_W'(want.found), INDEX_W'(found));
                    check_field("next_index", want.next_index, next_index);
                    check_field("index_error", INDEX_W'(want.index_error),
                                INDEX_W'(index_error));
                end
            end
            if (req_valid && !req_stall)
            begin
                want = apply_request(func_t'(func), bit_index);
                hit_count     += int'(want.found);
                flagged_count += int'(want.index_error);
                pending_results.push_back(want);
            end
            // Registered so that the stimulus side reads it without a race.
            pending <= pending_results.size();
        end
    end

endmodule

/* tb/tb_top.sv */
// Testbench top for the bitmap block: clock, reset, request and response traffic, verdict.
`timescale 1ns / 100ps

module tb_top
    import bmfns_pkg::*;
();

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int MAP_BITS    = MAX_BITS_DEF;
    localparam int NUM_SEGS    = 7;

    logic                    clk         = 1'b0;
    logic                    rst_n       = 1'b0;
    logic                    cfg_wr_en   = 1'b0;
    logic [VALID_BITS_W-1:0] cfg_wr_data = '0;
    logic                    req_valid   = 1'b0;
    logic                    req_stall;
    logic [1:0]              func        = '0;
    logic [INDEX_W-1:0]      bit_index   = '0;
    logic                    rsp_valid;
    logic                    rsp_stall   = 1'b0;
    logic                    bit_value;
    logic                    found;
    logic [INDEX_W-1:0]      next_index;
    logic                    index_error;

    int fail_count;
    int pending;
    int hit_count;
    int flagged_count;
    int cycle_count   = 0;
    int items_sent    = 0;
    int send_idle_pct = 37;
    int rcv_idle_pct  = 82;
    int unsigned eff_len = MAP_BITS;

    logic [VALID_BITS_W-1:0] seg_len [NUM_SEGS];
    int seg_items [NUM_SEGS] = '{250, 60, 400, 40, 350, 350, 300};

    bitmap_set_with_next_set_search_top i_dut (.*);

    bitmap_checker i_checker (.*);

    always #1 clk = ~clk;

    always @(posedge clk)
        rsp_stall <= ($urandom_range(0, 99) < rcv_idle_pct);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Holds the request until its transfer; valid stays up so back-to-back items need no gap.
    task automatic issue_request(input func_t op, input logic [INDEX_W-1:0] idx);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        func      <= op;
        bit_index <= idx;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_map_idle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_length(input logic [VALID_BITS_W-1:0] len);
        wait_map_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        eff_len = (len > MAP_BITS) ? MAP_BITS : len;
    endtask

    function automatic func_t pick_func();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return FUNC_SET;
        if (r < 50)
            return FUNC_CLEAR;
        if (r < 70)
            return FUNC_TEST;
        return FUNC_FIND;
    endfunction

    // Mostly in-range indices, with the last bit of a word, the ends and some out-of-range noise.
    function automatic logic [INDEX_W-1:0] pick_index(input int unsigned len);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (len == 0 || r < 6)
            return INDEX_W'($urandom_range(0, MAP_BITS - 1));
        if (r < 12)
            return INDEX_W'(len - 1);
        if (r < 16)
            return '0;
        if (r < 32)
            return INDEX_W'($urandom_range(0, (len - 1) / WORD_BITS) * WORD_BITS
                            + WORD_BITS - 1);
        return INDEX_W'($urandom_range(0, len - 1));
    endfunction

    initial
    begin
        seg_len = '{13'd64, 13'd1, 13'd4096, 13'd0, 13'd8191, 13'd1, 13'd4095};
        seg_len[5] = VALID_BITS_W'($urandom_range(1, MAP_BITS));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset length: empty map, word boundaries, top bit.
        issue_request(FUNC_TEST, 12'd0);
        issue_request(FUNC_FIND, 12'd0);
        issue_request(FUNC_SET, 12'd0);
        issue_request(FUNC_SET, 12'd63);
        issue_request(FUNC_SET, 12'd64);
        issue_request(FUNC_SET, 12'd4095);
        issue_request(FUNC_SET, 12'd200);
        issue_request(FUNC_TEST, 12'd4095);
        issue_request(FUNC_FIND, 12'd0);
        issue_request(FUNC_FIND, 12'd63);
        issue_request(FUNC_FIND, 12'd64);
        issue_request(FUNC_FIND, 12'd4095);
        issue_request(FUNC_CLEAR, 12'd4095);
        issue_request(FUNC_TEST, 12'd4095);
        issue_request(FUNC_CLEAR, 12'd1);

        // A shorter length hides bit 200 and turns high indices into errors.
        write_length(13'd100);
        issue_request(FUNC_FIND, 12'd64);
        issue_request(FUNC_SET, 12'd100);
        issue_request(FUNC_FIND, 12'd4095);
        issue_request(FUNC_SET, 12'd99);
        issue_request(FUNC_FIND, 12'd70);
        issue_request(FUNC_TEST, 12'd99);

        write_length(13'd0);
        issue_request(FUNC_TEST, 12'd0);

        // All ones saturates to the full map size.
        write_length(13'd8191);
        issue_request(FUNC_FIND, 12'd99);
        issue_request(FUNC_SET, 12'd4095);
        issue_request(FUNC_FIND, 12'd200);

        for (int s = 0; s < NUM_SEGS; s++)
        begin
            if (s == 3)
            begin
                send_idle_pct = 82;
                rcv_idle_pct  = 37;
            end
            else if (s == 5)
            begin
                send_idle_pct = 0;
                rcv_idle_pct  = 0;
            end
            write_length(seg_len[s]);
            for (int n = 0; n < seg_items[s]; n++)
            begin
                if ($urandom_range(0, 199) == 0)
                    wait_map_idle();
                issue_request(pick_func(), pick_index(eff_len));
            end
        end

        wait_map_idle();
        repeat (80) @(posedge clk);
        $display("Ran %0d requests over %0d length settings, zero through saturation.",
                 items_sent, NUM_SEGS + 4);
        $display("%0d searches found a bit and %0d requests were out of range.",
                 hit_count, flagged_count);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/bmfns_pkg.sv
hw/rtl/bmfns_ram.sv
hw/rtl/bitmap_set_with_next_set_search_top.sv
tb/bitmap_checker.sv
tb/tb_top.sv
